// File: hw/rtl/gfa_pkg.sv
// types and constants for the goldilocks field arithmetic unit
`default_nettype none
package gfa_pkg;
  localparam logic [63:0] GL_P   = 64'hFFFF_FFFF_0000_0001;
  localparam logic [63:0] GL_EPS = 64'h0000_0000_FFFF_FFFF;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_NEG = 3'd2;
  localparam logic [2:0] MODE_MUL = 3'd3;
  localparam logic [2:0] MODE_POW = 3'd4;
  localparam logic [2:0] MODE_INV = 3'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } gfa_in_t;

  typedef struct packed {
    logic [63:0] value;
    logic        zero_inverse;
  } gfa_out_t;

  function automatic logic [63:0] canon(input logic [63:0] x);
    canon = (x >= GL_P) ? x - GL_P : x;
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/goldilocks_field_alu.sv
// goldilocks prime field unit: add, sub, neg; mul, pow, inverse on one shared multiplier
// each modular multiply runs 4 partial products and 2 reduction steps; pow and inverse
// add 1 step decision per multiply; worst pow has 63 squarings and 64 multiplies,
// inverse 126 multiplies for its fixed exponent p - 2
// one item at a time: next input transfer in the cycle out_valid rises; a held result
// stalls the sequencer in its done state; reset (rst_n, synchronous) clears sequencer, valid
`default_nettype none
module goldilocks_field_alu (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire gfa_pkg::gfa_in_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output gfa_pkg::gfa_out_t    out_data
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SEL  = 7'b0000010,
    S_PP   = 7'b0000100,
    S_RED1 = 7'b0001000,
    S_RED2 = 7'b0010000,
    S_NEXT = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [63:0]  acc_r, base_r, exp_r;
  logic [2:0]   mode_r;
  logic         sq_r;          // current multiply is the squaring of base
  logic [63:0]  ma_r, mb_r;
  logic [1:0]   pp_cnt_r;
  logic [127:0] prod_r;
  logic [63:0]  t0_r;
  logic [63:0]  t1_r;
  logic [63:0]  res_r;
  logic         zinv_r;
  gfa_pkg::gfa_out_t out_r;
  logic         out_valid_r;

  // shared 32x32 multiplier, one partial product per cycle
  logic [31:0] mx, my;
  logic [63:0] pp;
  assign mx = pp_cnt_r[0] ? ma_r[63:32] : ma_r[31:0];
  assign my = pp_cnt_r[1] ? mb_r[63:32] : mb_r[31:0];
  assign pp = {32'd0, mx} * {32'd0, my};

  // simple ops
  logic [64:0] sum_w;
  logic [63:0] add_w, sub_w, neg_w, ca, cb, s1;
  logic [64:0] s2;
  always_comb begin
    sum_w = {1'b0, in_data.operand_a} + {1'b0, in_data.operand_b};
    s1 = sum_w[63:0];
    if (sum_w[64]) begin
      s2 = {1'b0, s1} + {1'b0, gfa_pkg::GL_EPS};
      s1 = s2[64] ? s2[63:0] + gfa_pkg::GL_EPS : s2[63:0];
    end else begin
      s2 = '0;
    end
    add_w = gfa_pkg::canon(s1);
    ca = gfa_pkg::canon(in_data.operand_a);
    cb = gfa_pkg::canon(in_data.operand_b);
    sub_w = (ca >= cb) ? ca - cb : ca + (gfa_pkg::GL_P - cb);
    neg_w = (ca == 64'd0) ? 64'd0 : gfa_pkg::GL_P - ca;
  end

  // reduction: hi/lo of product
  logic [63:0] lo_w, hh_w, hl_w, t0_w;
  assign lo_w = prod_r[63:0];
  assign hh_w = {32'd0, prod_r[127:96]};
  assign hl_w = {32'd0, prod_r[95:64]};
  assign t0_w = (lo_w < hh_w) ? lo_w - hh_w - gfa_pkg::GL_EPS : lo_w - hh_w;
  logic [64:0] t2_w;
  logic [63:0] red_w;
  always_comb begin
    t2_w = {1'b0, t0_r} + {1'b0, t1_r};
    red_w = gfa_pkg::canon(t2_w[64] ? t2_w[63:0] + gfa_pkg::GL_EPS : t2_w[63:0]);
  end

  // the output register holds a finished result while the next item runs
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic in_fire, done_go;
  assign in_fire = in_valid && in_ready;
  assign done_go = (state_r == S_DONE) && !(out_valid_r && !out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_SEL;
      S_SEL: begin
        if (mode_r == gfa_pkg::MODE_MUL) state_nxt = S_PP;
        else if (mode_r == gfa_pkg::MODE_POW || (mode_r == gfa_pkg::MODE_INV && !zinv_r)) begin
          if (exp_r == 64'd0) state_nxt = S_DONE;
          else state_nxt = S_PP;
        end else state_nxt = S_DONE;
      end
      S_PP:   if (pp_cnt_r == 2'd3) state_nxt = S_RED1;
      S_RED1: state_nxt = S_RED2;
      S_RED2: state_nxt = (mode_r == gfa_pkg::MODE_MUL) ? S_DONE : S_NEXT;
      // finished once a multiply has used the last set exponent bit
      S_NEXT: state_nxt = (!sq_r && exp_r[63:1] == 63'd0) ? S_DONE : S_PP;
      S_DONE: if (done_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (done_go) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        mode_r   <= in_data.mode;
        base_r   <= in_data.operand_a;
        acc_r    <= 64'd1;
        ma_r     <= in_data.operand_a;
        mb_r     <= in_data.operand_b;
        zinv_r   <= (in_data.mode == gfa_pkg::MODE_INV) && (ca == 64'd0);
        exp_r    <= (in_data.mode == gfa_pkg::MODE_INV) ? gfa_pkg::GL_P - 64'd2
                                                       : in_data.operand_b;
        unique case (in_data.mode)
          gfa_pkg::MODE_ADD: res_r <= add_w;
          gfa_pkg::MODE_SUB: res_r <= sub_w;
          gfa_pkg::MODE_NEG: res_r <= neg_w;
          default:           res_r <= 64'd0;
        endcase
      end
      S_SEL: begin
        pp_cnt_r <= 2'd0;
        prod_r   <= '0;
        if (mode_r != gfa_pkg::MODE_MUL) begin
          // first step: multiply acc by base if bit set, else drop the bit and square base
          sq_r <= !exp_r[0];
          ma_r <= exp_r[0] ? acc_r : base_r;
          mb_r <= base_r;
          if (!exp_r[0]) exp_r <= exp_r >> 1;
          if (mode_r == gfa_pkg::MODE_POW || (mode_r == gfa_pkg::MODE_INV && !zinv_r))
            res_r <= acc_r;
        end
      end
      S_PP: begin
        prod_r <= prod_r + ({64'd0, pp} << {({1'b0, pp_cnt_r[1]} + {1'b0, pp_cnt_r[0]}),
                                            5'd0});
        pp_cnt_r <= pp_cnt_r + 2'd1;
      end
      S_RED1: begin
        t0_r <= t0_w;
        t1_r <= (hl_w << 32) - hl_w;
      end
      S_RED2: begin
        res_r <= red_w;
        if (mode_r != gfa_pkg::MODE_MUL) begin
          if (sq_r) base_r <= red_w;
          else acc_r <= red_w;
        end
      end
      S_NEXT: begin
        prod_r   <= '0;
        pp_cnt_r <= 2'd0;
        if (!sq_r) begin
          // multiply done; shift exponent, then square if bits remain
          exp_r <= exp_r >> 1;
          sq_r  <= 1'b1;
          ma_r  <= base_r;
          mb_r  <= base_r;
          res_r <= acc_r;
        end else begin
          // squaring done; the bit for this base power is at exp_r[0]
          if (exp_r[0]) begin
            sq_r <= 1'b0;
            ma_r <= acc_r;
            mb_r <= base_r;
          end else begin
            exp_r <= exp_r >> 1;
            ma_r  <= base_r;
            mb_r  <= base_r;
          end
        end
      end
      S_DONE: if (done_go) begin
        out_r.value        <= gfa_pkg::canon(res_r);
        out_r.zero_inverse <= zinv_r;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
